### rtl/core/fce_pkg.sv
`default_nettype none

package fce_pkg;

    // link codes
    localparam logic [15:0] LINK_END  = 16'hFFFF;
    localparam logic [15:0] LINK_FREE = 16'h0000;

    // operation codes
    localparam logic [2:0] OP_LOAD   = 3'd0;
    localparam logic [2:0] OP_READ   = 3'd1;
    localparam logic [2:0] OP_SEEK   = 3'd2;
    localparam logic [2:0] OP_APPEND = 3'd3;
    localparam logic [2:0] OP_FREE   = 3'd4;
    localparam logic [2:0] OP_COUNT  = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_END   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_LIMIT = 2'd3;

    // block count after reset
    localparam logic [12:0] BLOCK_COUNT_RESET = 13'd4096;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_WALK,
        S_WALK_DATA,
        S_SCAN,
        S_SCAN_DATA,
        S_LINK,
        S_FIN
    } fce_state_t;

    // request word
    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] start_block;
        logic [23:0] file_offset;
        logic [11:0] entry_index;
        logic [15:0] entry_value;
    } fce_req_t;

    // response word
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] block_index;
        logic [15:0] chain_head;
        logic [12:0] free_count;
        logic [15:0] read_value;
    } fce_rsp_t;

endpackage

`default_nettype wire

### rtl/core/fat_chain_engine.sv
`default_nettype none

// channel  | signals                      | direction | width
// request  | req_valid req_ready req_word | in        | fce_req_t (71)
// response | rsp_valid rsp_ready rsp_word | out       | fce_rsp_t (63)
// config   | cfg_we cfg_data              | in        | 13
//
// one word at a time; every table access goes through the link memory, which has one read
// and one write port and a registered read, so each link followed or entry scanned passes
// through an issue state and a data state (S_WALK/S_WALK_DATA, S_SCAN/S_SCAN_DATA).
// append walks to the tail and then searches for a free entry; count scans the table.
// the table is not cleared at reset; entries hold garbage until loaded.
// a finished word waits in the response register; the next request is taken
// once the sequencer is back in idle.
module fat_chain_engine #(
    parameter int TABLE_DEPTH = 4096,
    parameter int BLOCK_BYTES = 4096
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  wire fce_pkg::fce_req_t req_word,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    output fce_pkg::fce_rsp_t     rsp_word,
    input  wire logic             cfg_we,
    input  wire logic [12:0]      cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = ($clog2(TABLE_DEPTH + 1) > 13) ? $clog2(TABLE_DEPTH + 1) : 13;
    localparam logic [16:0] DEPTH_L = 17'(TABLE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [24:0] BLK_L = 25'(BLOCK_BYTES);

    // link memory
    logic [15:0]   mem [TABLE_DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [15:0]   mem_q;

    // control and working registers
    fce_pkg::fce_state_t state_reg, state_next;
    logic [12:0]   cfg_reg;
    logic          rsp_valid_reg, rsp_valid_next;
    fce_pkg::fce_rsp_t rsp_reg, rsp_next;
    logic [2:0]    op_reg, op_next;
    logic [15:0]   cur_reg, cur_next;
    logic [15:0]   prev_reg, prev_next;
    logic [23:0]   rem_reg, rem_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] i_reg, i_next;
    logic          oor_reg, oor_next;
    logic [1:0]    status_reg, status_next;
    logic [15:0]   blk_reg, blk_next;
    logic [15:0]   head_reg, head_next;
    logic [12:0]   cnt_reg, cnt_next;
    logic [15:0]   rval_reg, rval_next;

    // derived values
    logic [CW-1:0] cfg_ext;
    logic [CW-1:0] bound;
    logic [16:0]   entry_ext;
    logic          entry_in_range;
    logic          cur_in_range;
    logic          prev_in_range;
    logic          rem_has_block;
    logic [24:0]   rem_diff;
    logic [15:0]   link_data;
    logic          accept;

    assign cfg_ext        = CW'(cfg_reg);
    assign bound          = (cfg_ext < DEPTH_C) ? cfg_ext : DEPTH_C;
    assign entry_ext      = {5'b0, req_word.entry_index};
    assign entry_in_range = entry_ext < DEPTH_L;
    assign cur_in_range   = {1'b0, cur_reg} < DEPTH_L;
    assign prev_in_range  = {1'b0, prev_reg} < DEPTH_L;
    assign rem_has_block  = {1'b0, rem_reg} >= BLK_L;
    assign rem_diff       = {1'b0, rem_reg} - BLK_L;
    assign link_data      = oor_reg ? fce_pkg::LINK_END : mem_q;

    assign req_ready = (state_reg == fce_pkg::S_IDLE);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_reg;

    // memory port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q <= mem[mem_raddr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fce_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
            cfg_reg       <= fce_pkg::BLOCK_COUNT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                cfg_reg <= cfg_data;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        rsp_reg    <= rsp_next;
        op_reg     <= op_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        rem_reg    <= rem_next;
        n_reg      <= n_next;
        i_reg      <= i_next;
        oor_reg    <= oor_next;
        status_reg <= status_next;
        blk_reg    <= blk_next;
        head_reg   <= head_next;
        cnt_reg    <= cnt_next;
        rval_reg   <= rval_next;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        op_next        = op_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        rem_next       = rem_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        oor_next       = oor_reg;
        status_next    = status_reg;
        blk_next       = blk_reg;
        head_next      = head_reg;
        cnt_next       = cnt_reg;
        rval_next      = rval_reg;
        mem_we         = 1'b0;
        mem_waddr      = cur_reg[AW-1:0];
        mem_wdata      = fce_pkg::LINK_FREE;
        mem_raddr      = cur_reg[AW-1:0];

        // response taken
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            fce_pkg::S_IDLE:
            begin
                mem_raddr = entry_ext[AW-1:0];
                if (accept)
                begin
                    op_next     = req_word.opcode;
                    cur_next    = req_word.start_block;
                    prev_next   = fce_pkg::LINK_END;
                    rem_next    = req_word.file_offset;
                    n_next      = '0;
                    i_next      = '0;
                    oor_next    = 1'b0;
                    status_next = fce_pkg::ST_OK;
                    blk_next    = '0;
                    head_next   = '0;
                    cnt_next    = '0;
                    rval_next   = '0;
                    case (req_word.opcode)
                        fce_pkg::OP_LOAD:
                        begin
                            mem_we     = entry_in_range;
                            mem_waddr  = entry_ext[AW-1:0];
                            mem_wdata  = (req_word.entry_index == '0) ? fce_pkg::LINK_END
                                                                      : req_word.entry_value;
                            state_next = fce_pkg::S_FIN;
                        end
                        fce_pkg::OP_READ:
                        begin
                            oor_next   = !entry_in_range;
                            state_next = fce_pkg::S_READ;
                        end
                        fce_pkg::OP_SEEK, fce_pkg::OP_FREE:
                        begin
                            state_next = fce_pkg::S_WALK;
                        end
                        fce_pkg::OP_APPEND:
                        begin
                            head_next  = req_word.start_block;
                            blk_next   = fce_pkg::LINK_END;
                            state_next = fce_pkg::S_WALK;
                        end
                        fce_pkg::OP_COUNT:
                        begin
                            i_next     = CW'(1);
                            state_next = fce_pkg::S_SCAN;
                        end
                        default:
                        begin
                            state_next = fce_pkg::S_FIN;
                        end
                    endcase
                end
            end

            fce_pkg::S_READ:
            begin
                rval_next  = link_data;
                state_next = fce_pkg::S_FIN;
            end

            // check walk end, else issue the read of the current link
            fce_pkg::S_WALK:
            begin
                oor_next = !cur_in_range;
                if (op_reg == fce_pkg::OP_SEEK && (!rem_has_block || cur_reg == fce_pkg::LINK_END))
                begin
                    status_next = (cur_reg == fce_pkg::LINK_END) ? fce_pkg::ST_END
                                                                 : fce_pkg::ST_OK;
                    blk_next    = cur_reg;
                    state_next  = fce_pkg::S_FIN;
                end
                else if (op_reg == fce_pkg::OP_APPEND && cur_reg == fce_pkg::LINK_END)
                begin
                    i_next     = '0;
                    state_next = fce_pkg::S_SCAN;
                end
                else if (cur_reg == fce_pkg::LINK_END)
                begin
                    state_next = fce_pkg::S_FIN;
                end
                else if (n_reg == bound)
                begin
                    status_next = fce_pkg::ST_LIMIT;
                    if (op_reg != fce_pkg::OP_FREE)
                    begin
                        blk_next = fce_pkg::LINK_END;
                    end
                    state_next  = fce_pkg::S_FIN;
                end
                else
                begin
                    prev_next  = cur_reg;
                    state_next = fce_pkg::S_WALK_DATA;
                end
            end

            // follow the link just read; free also clears the entry
            fce_pkg::S_WALK_DATA:
            begin
                if (op_reg == fce_pkg::OP_FREE)
                begin
                    mem_we = cur_in_range;
                end
                if (op_reg == fce_pkg::OP_SEEK)
                begin
                    rem_next = rem_diff[23:0];
                end
                cur_next   = link_data;
                n_next     = n_reg + CW'(1);
                state_next = fce_pkg::S_WALK;
            end

            // issue the read of the next table entry
            fce_pkg::S_SCAN:
            begin
                mem_raddr = i_reg[AW-1:0];
                if (i_reg >= bound)
                begin
                    if (op_reg == fce_pkg::OP_APPEND)
                    begin
                        status_next = fce_pkg::ST_FULL;
                    end
                    state_next = fce_pkg::S_FIN;
                end
                else
                begin
                    state_next = fce_pkg::S_SCAN_DATA;
                end
            end

            // test the entry for free; append claims it, count counts it
            fce_pkg::S_SCAN_DATA:
            begin
                state_next = fce_pkg::S_SCAN;
                i_next     = i_reg + CW'(1);
                if (mem_q == fce_pkg::LINK_FREE)
                begin
                    if (op_reg == fce_pkg::OP_APPEND)
                    begin
                        mem_we      = 1'b1;
                        mem_waddr   = i_reg[AW-1:0];
                        mem_wdata   = fce_pkg::LINK_END;
                        blk_next    = 16'(i_reg);
                        status_next = fce_pkg::ST_OK;
                        i_next      = i_reg;
                        if (prev_reg == fce_pkg::LINK_END)
                        begin
                            head_next  = 16'(i_reg);
                            state_next = fce_pkg::S_FIN;
                        end
                        else
                        begin
                            state_next = fce_pkg::S_LINK;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 13'd1;
                    end
                end
            end

            // point the old tail at the claimed block
            fce_pkg::S_LINK:
            begin
                mem_we     = prev_in_range;
                mem_waddr  = prev_reg[AW-1:0];
                mem_wdata  = 16'(i_reg);
                state_next = fce_pkg::S_FIN;
            end

            // hand the result to the response register
            fce_pkg::S_FIN:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.status      = status_reg;
                    rsp_next.block_index = blk_reg;
                    rsp_next.chain_head  = head_reg;
                    rsp_next.free_count  = cnt_reg;
                    rsp_next.read_value  = rval_reg;
                    rsp_valid_next       = 1'b1;
                    state_next           = fce_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = fce_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int TBL_DEPTH = 4096;
    localparam int BLK_BYTES = 4096;
    localparam int INIT_SPAN = 128;
    localparam longint LIMIT_NS = 64'd40_000_000;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    // block ports
    logic        req_valid = 1'b0;
    logic        req_ready;
    fce_pkg::fce_req_t req_word = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    fce_pkg::fce_rsp_t rsp_word;
    logic        cfg_we = 1'b0;
    logic [12:0] cfg_data = fce_pkg::BLOCK_COUNT_RESET;

    fat_chain_engine #(
        .TABLE_DEPTH(TBL_DEPTH),
        .BLOCK_BYTES(BLK_BYTES)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_word (req_word),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp_word (rsp_word),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // shadow of the link table and the block count
    logic [15:0] fat_link [TBL_DEPTH];
    logic [12:0] blk_count = fce_pkg::BLOCK_COUNT_RESET;

    // request words waiting for the driver, response words still owed
    fce_pkg::fce_req_t req_pending[$];
    fce_pkg::fce_rsp_t rsp_due[$];
    fce_pkg::fce_rsp_t last_rsp;
    int       sent_cnt = 0;
    int       taken_cnt = 0;
    int       mismatch_cnt = 0;
    int       req_gap = 0;
    int       rsp_stall = 0;
    bit       idle_on = 1'b0;
    int       chain_heads[$];

    function automatic logic [15:0] link_at(input int unsigned idx);
        if (idx >= TBL_DEPTH)
            return fce_pkg::LINK_END;
        return fat_link[idx];
    endfunction

    function automatic void link_put(input int unsigned idx, input logic [15:0] val);
        if (idx < TBL_DEPTH)
            fat_link[idx] = val;
    endfunction

    // applies one request word to the shadow table and returns its response
    function automatic fce_pkg::fce_rsp_t fat_outcome(input fce_pkg::fce_req_t r);
        fce_pkg::fce_rsp_t o;
        int unsigned bound;
        int unsigned steps;
        int unsigned n;
        int unsigned cur;
        int unsigned prev;
        int unsigned nxt;
        int unsigned i;
        o = '0;
        bound = (blk_count < TBL_DEPTH) ? blk_count : TBL_DEPTH;
        n = 0;
        cur = r.start_block;
        case (r.opcode)
            fce_pkg::OP_LOAD:
            begin
                link_put(r.entry_index,
                         (r.entry_index == 0) ? fce_pkg::LINK_END : r.entry_value);
            end
            fce_pkg::OP_READ:
            begin
                o.read_value = link_at(r.entry_index);
            end
            fce_pkg::OP_SEEK:
            begin
                steps = r.file_offset / BLK_BYTES;
                while (n < steps && cur != fce_pkg::LINK_END && o.status != fce_pkg::ST_LIMIT)
                begin
                    if (n == bound)
                        o.status = fce_pkg::ST_LIMIT;
                    else
                    begin
                        cur = link_at(cur);
                        n++;
                    end
                end
                if (o.status == fce_pkg::ST_LIMIT)
                    o.block_index = fce_pkg::LINK_END;
                else if (cur == fce_pkg::LINK_END)
                begin
                    o.status = fce_pkg::ST_END;
                    o.block_index = fce_pkg::LINK_END;
                end
                else
                    o.block_index = 16'(cur);
            end
            fce_pkg::OP_APPEND:
            begin
                prev = fce_pkg::LINK_END;
                o.chain_head = r.start_block;
                o.block_index = fce_pkg::LINK_END;
                // walk to the tail
                while (cur != fce_pkg::LINK_END && o.status != fce_pkg::ST_LIMIT)
                begin
                    if (n == bound)
                        o.status = fce_pkg::ST_LIMIT;
                    else
                    begin
                        prev = cur;
                        cur = link_at(cur);
                        n++;
                    end
                end
                // claim the first free entry
                if (o.status != fce_pkg::ST_LIMIT)
                begin
                    o.status = fce_pkg::ST_FULL;
                    for (i = 0; i < bound && o.status == fce_pkg::ST_FULL; i++)
                    begin
                        if (fat_link[i] == fce_pkg::LINK_FREE)
                        begin
                            fat_link[i] = fce_pkg::LINK_END;
                            if (prev == fce_pkg::LINK_END)
                                o.chain_head = 16'(i);
                            else
                                link_put(prev, 16'(i));
                            o.block_index = 16'(i);
                            o.status = fce_pkg::ST_OK;
                        end
                    end
                end
            end
            fce_pkg::OP_FREE:
            begin
                while (cur != fce_pkg::LINK_END && o.status != fce_pkg::ST_LIMIT)
                begin
                    if (n == bound)
                        o.status = fce_pkg::ST_LIMIT;
                    else
                    begin
                        nxt = link_at(cur);
                        link_put(cur, fce_pkg::LINK_FREE);
                        cur = nxt;
                        n++;
                    end
                end
            end
            fce_pkg::OP_COUNT:
            begin
                for (i = 1; i < bound; i++)
                    if (fat_link[i] == fce_pkg::LINK_FREE)
                        o.free_count++;
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            mismatch_cnt++;
            if (mismatch_cnt <= 100)
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endfunction

    // request driver: one word at a time, random gap after each accepted word while idle_on is set
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_gap = 0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                last_rsp = fat_outcome(req_word);
                rsp_due.push_back(last_rsp);
                taken_cnt++;
                req_gap = idle_on ? $urandom_range(0, 17) : 0;
            end
            if (!req_valid || req_ready)
            begin
                if (req_gap > 0)
                begin
                    req_gap--;
                    req_valid <= 1'b0;
                end
                else if (req_pending.size() != 0)
                begin
                    req_valid <= 1'b1;
                    req_word <= req_pending.pop_front();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // response monitor: compare each word, random stall after each one while idle_on is set
    always @(posedge clk or negedge rst_n)
    begin
        fce_pkg::fce_rsp_t want;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            rsp_stall = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (rsp_due.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 100)
                        $display("%0t: response word %h with nothing expected, expected none",
                                 $time, rsp_word);
                end
                else
                begin
                    want = rsp_due.pop_front();
                    check_field("status", want.status, rsp_word.status);
                    check_field("block_index", want.block_index, rsp_word.block_index);
                    check_field("chain_head", want.chain_head, rsp_word.chain_head);
                    check_field("free_count", want.free_count, rsp_word.free_count);
                    check_field("read_value", want.read_value, rsp_word.read_value);
                end
                rsp_stall = idle_on ? $urandom_range(0, 17) : 0;
            end
            if (rsp_stall > 0)
            begin
                rsp_stall--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    task automatic issue(input logic [2:0] op, input logic [15:0] start,
                         input logic [23:0] offset, input logic [11:0] idx,
                         input logic [15:0] value);
        fce_pkg::fce_req_t r;
        r.opcode = op;
        r.start_block = start;
        r.file_offset = offset;
        r.entry_index = idx;
        r.entry_value = value;
        req_pending.push_back(r);
        sent_cnt++;
    endtask

    task automatic wait_taken();
        while (taken_cnt != sent_cnt)
            @(negedge clk);
    endtask

    // every word accepted and answered
    task automatic wait_drained();
        wait_taken();
        while (rsp_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_block_count(input int count);
        wait_drained();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= 13'(count);
        blk_count = 13'(count);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // table index near the active region, now and then anywhere in the loaded span
    function automatic logic [11:0] near_index();
        int lim;
        lim = (blk_count + 1 > INIT_SPAN - 1) ? INIT_SPAN - 1 : blk_count + 1;
        if ($urandom_range(0, 3) == 0)
            return 12'($urandom_range(0, INIT_SPAN - 1));
        return 12'($urandom_range(0, lim));
    endfunction

    // a block inside the loaded span or beyond the table
    function automatic logic [15:0] stray_link();
        if ($urandom_range(0, 1) != 0)
            return 16'($urandom_range(0, INIT_SPAN - 1));
        return 16'($urandom_range(TBL_DEPTH, 65535));
    endfunction

    // link value for a load
    function automatic logic [15:0] some_link();
        case ($urandom_range(0, 3))
            0: return fce_pkg::LINK_FREE;
            1: return fce_pkg::LINK_END;
            2: return 16'(near_index());
            default: return stray_link();
        endcase
    endfunction

    // a tracked chain head most of the time, else empty or noise
    function automatic logic [15:0] some_head();
        int k;
        if (chain_heads.size() != 0 && $urandom_range(0, 4) != 0)
        begin
            k = $urandom_range(0, chain_heads.size() - 1);
            return 16'(chain_heads[k]);
        end
        return ($urandom_range(0, 1) != 0) ? fce_pkg::LINK_END : stray_link();
    endfunction

    // one random word, mostly chain work on tracked heads
    task automatic random_op();
        logic [2:0]  op;
        logic [15:0] start;
        logic [23:0] offset;
        logic [11:0] idx;
        logic [15:0] value;
        int          pick;
        int          k;
        op = 3'($urandom_range(0, 7));
        start = some_head();
        offset = 24'($urandom_range(0, 24'hFFFFFF));
        idx = near_index();
        value = some_link();
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            op = fce_pkg::OP_APPEND;
            start = ($urandom_range(0, 3) == 0) ? fce_pkg::LINK_END : some_head();
            issue(op, start, offset, idx, value);
            wait_taken();
            if (last_rsp.status == fce_pkg::ST_OK && start == fce_pkg::LINK_END
                && chain_heads.size() < 6)
                chain_heads.push_back(last_rsp.chain_head);
        end
        else
        begin
            if (pick < 50)
            begin
                op = fce_pkg::OP_SEEK;
                start = some_head();
                if ($urandom_range(0, 3) != 0)
                    offset = 24'($urandom_range(0, 6) * BLK_BYTES
                                 + $urandom_range(0, BLK_BYTES - 1));
            end
            else if (pick < 60)
            begin
                op = fce_pkg::OP_FREE;
                start = some_head();
                for (k = chain_heads.size() - 1; k >= 0; k--)
                    if (chain_heads[k] == start)
                        chain_heads.delete(k);
            end
            else if (pick < 68)
                op = fce_pkg::OP_COUNT;
            else if (pick < 78)
                op = fce_pkg::OP_READ;
            else if (pick < 92)
                op = fce_pkg::OP_LOAD;
            // a count past the loaded span would read undefined entries
            if (op == fce_pkg::OP_COUNT && blk_count > INIT_SPAN)
                op = fce_pkg::OP_READ;
            issue(op, start, offset, idx, value);
        end
    endtask

    // stimulus
    initial
    begin
        logic [15:0] head;
        int          i;
        int          ph;
        int          count;
        int          n_items;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // define the table entries that anything reads
        idle_on = 1'b0;
        for (i = 0; i < INIT_SPAN; i++)
            issue(fce_pkg::OP_LOAD, 16'h0, 24'h0, 12'(i), fce_pkg::LINK_FREE);
        wait_drained();

        // directed words at the full block count
        idle_on = 1'b1;
        issue(fce_pkg::OP_READ, 16'h0, 24'h0, 12'h0, 16'h0);
        // entry 0 always stays end of chain
        issue(fce_pkg::OP_LOAD, 16'h0, 24'h0, 12'h0, 16'h1234);
        issue(fce_pkg::OP_READ, 16'h0, 24'h0, 12'h0, 16'h0);
        // build a three block chain from empty
        issue(fce_pkg::OP_APPEND, fce_pkg::LINK_END, 24'h0, 12'h0, 16'h0);
        wait_taken();
        head = last_rsp.chain_head;
        issue(fce_pkg::OP_APPEND, head, 24'h0, 12'h0, 16'h0);
        issue(fce_pkg::OP_APPEND, head, 24'h0, 12'h0, 16'h0);
        issue(fce_pkg::OP_SEEK, head, 24'h0, 12'h0, 16'h0);
        issue(fce_pkg::OP_SEEK, head, 24'(2 * BLK_BYTES + BLK_BYTES - 1), 12'h0, 16'h0);
        issue(fce_pkg::OP_SEEK, head, 24'hFFFFFF, 12'h0, 16'h0);
        issue(fce_pkg::OP_SEEK, fce_pkg::LINK_END, 24'h0, 12'h0, 16'h0);
        // out of range block reads as end of chain
        issue(fce_pkg::OP_SEEK, 16'hFFFE, 24'(BLK_BYTES), 12'h0, 16'h0);
        issue(fce_pkg::OP_LOAD, 16'h0, 24'h0, 12'hFFF, fce_pkg::LINK_END);
        issue(fce_pkg::OP_READ, 16'h0, 24'h0, 12'hFFF, 16'h0);
        issue(fce_pkg::OP_LOAD, 16'h0, 24'h0, 12'hFFD, 16'hFFFE);
        issue(fce_pkg::OP_SEEK, 16'hFFD, 24'(2 * BLK_BYTES), 12'h0, 16'h0);
        // two block loop: append hits the walk limit, long seek goes around
        issue(fce_pkg::OP_LOAD, 16'h0, 24'h0, 12'd10, 16'd11);
        issue(fce_pkg::OP_LOAD, 16'h0, 24'h0, 12'd11, 16'd10);
        issue(fce_pkg::OP_APPEND, 16'd10, 24'h0, 12'h0, 16'h0);
        issue(fce_pkg::OP_SEEK, 16'd10, 24'hFFFFFF, 12'h0, 16'h0);
        issue(3'd6, 16'hFFFF, 24'hFFFFFF, 12'hFFF, 16'hFFFF);
        issue(3'd7, 16'hFFFF, 24'hFFFFFF, 12'hFFF, 16'hFFFF);
        issue(fce_pkg::OP_FREE, head, 24'h0, 12'h0, 16'h0);
        issue(fce_pkg::OP_FREE, fce_pkg::LINK_END, 24'h0, 12'h0, 16'h0);
        // count over the loaded span
        set_block_count(INIT_SPAN);
        issue(fce_pkg::OP_COUNT, 16'h0, 24'h0, 12'h0, 16'h0);

        // smallest block count: full table and walk limits
        set_block_count(1);
        issue(fce_pkg::OP_LOAD, 16'h0, 24'h0, 12'h0, fce_pkg::LINK_FREE);
        issue(fce_pkg::OP_APPEND, fce_pkg::LINK_END, 24'h0, 12'h0, 16'h0);
        issue(fce_pkg::OP_LOAD, 16'h0, 24'h0, 12'd1, 16'd2);
        issue(fce_pkg::OP_SEEK, 16'd1, 24'(2 * BLK_BYTES), 12'h0, 16'h0);
        issue(fce_pkg::OP_FREE, 16'd1, 24'h0, 12'h0, 16'h0);
        issue(fce_pkg::OP_COUNT, 16'h0, 24'h0, 12'h0, 16'h0);

        // random phases, each at its own block count
        for (ph = 0; ph < 12; ph++)
        begin
            if (ph == 0)
                count = 1;
            else if (ph == 6)
                count = 2;
            else if (ph == 11)
                count = TBL_DEPTH;
            else
                count = $urandom_range(3, 48);
            n_items = (ph == 11) ? 15 : 52;
            set_block_count(count);
            idle_on = (ph % 4 != 3);
            chain_heads.delete();
            for (i = 0; i < n_items; i++)
                random_op();
        end

        wait_drained();
        repeat (20) @(negedge clk);
        if (mismatch_cnt == 0 && rsp_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // run limit
    initial
    begin
        #(LIMIT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
